// ----- hw/rtl/msrr_pkg.sv -----
// ----------------------------------------------------------------------------
// msrr_pkg
// Shared types and codes for the multi-stage range remap block.
// ----------------------------------------------------------------------------
package msrr_pkg;

  localparam int unsigned WORD_W = 32;

  // mode codes of an input word
  localparam logic [1:0] MODE_WRITE     = 2'd0;
  localparam logic [1:0] MODE_XLATE     = 2'd1;
  localparam logic [1:0] MODE_CLEAR_LOW = 2'd2;

  typedef struct packed {
    logic [WORD_W-1:0] dest;
    logic [WORD_W-1:0] src;
    logic [WORD_W-1:0] len;
  } entry_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic wr_entry;
    logic clr_low;
    logic start_scan;
    logic scan;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic scan_done;
  } status_t;

endpackage

// ----- hw/rtl/msrr_ctrl.sv -----
// ----------------------------------------------------------------------------
// msrr_ctrl
// Controller: table clearing pass, command decode and scan sequencing.
// ----------------------------------------------------------------------------
module msrr_ctrl
  import msrr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [1:0] mode,
  input  status_t    status,
  output cmd_t       cmd,
  output logic       busy
);

  state_t state;
  state_t state_next;
  logic   take;

  assign take = start && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start && mode == MODE_XLATE) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.clear_step = (state == ST_CLEAR);
    cmd.wr_entry   = take && (mode == MODE_WRITE);
    cmd.clr_low    = take && (mode == MODE_CLEAR_LOW);
    cmd.start_scan = take && (mode == MODE_XLATE);
    cmd.scan       = (state == ST_SCAN);
    cmd.finish     = (state == ST_FINISH);
    busy           = (state != ST_IDLE);
  end

`ifndef SYNTH
  a_scan_follows_take: assert property (@(posedge clk) disable iff (rst)
    cmd.start_scan |=> state == ST_SCAN)
    else $error("translate word accepted but scan not entered");

  a_scan_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    status.scan_done |-> state == ST_SCAN)
    else $error("scan completion outside scan state");
`endif

endmodule

// ----- hw/rtl/msrr_datapath.sv -----
// ----------------------------------------------------------------------------
// msrr_datapath
// Range table memory, scan counters, range compare and lowest-result tracker.
// ----------------------------------------------------------------------------
module msrr_datapath
  import msrr_pkg::*;
#(
  parameter int unsigned NUM_STAGES        = 7,
  parameter int unsigned ENTRIES_PER_STAGE = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic [2:0]  stage,
  input  logic [5:0]  entry_index,
  input  logic [31:0] dest_start,
  input  logic [31:0] src_start,
  input  logic [31:0] span_len,
  input  logic [31:0] value,
  output status_t     status,
  output logic        done,
  output logic [31:0] mapped_value,
  output logic [31:0] lowest_so_far
);

  localparam int unsigned DEPTH = NUM_STAGES * ENTRIES_PER_STAGE;
  localparam int unsigned IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned AW    = $clog2(DEPTH + 1);
  localparam int unsigned EW    = $clog2(ENTRIES_PER_STAGE + 1);
  localparam int unsigned SW    = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;

  entry_t mem [DEPTH];
  entry_t rdata;

  logic [IW-1:0]     clr_addr;
  logic [AW-1:0]     addr;
  logic [AW-1:0]     base;
  logic [EW-1:0]     ent;
  logic [SW-1:0]     stg;
  logic              rd_vld;
  logic              rd_last;
  logic [WORD_W-1:0] cur_val;
  logic [WORD_W-1:0] lowest;

  logic              wr_ok;
  logic [AW-1:0]     wr_slot;
  logic              we;
  logic [IW-1:0]     waddr;
  entry_t            wdata;
  logic [WORD_W-1:0] diff;
  logic              hit;
  logic              term;
  logic              stage_end;
  logic              rd_en;
  logic [WORD_W-1:0] lowest_next;

  // write port: clearing pass or a write word
  assign wr_ok   = (32'(stage) < NUM_STAGES) && (32'(entry_index) < ENTRIES_PER_STAGE);
  assign wr_slot = AW'(stage) * AW'(ENTRIES_PER_STAGE) + AW'(entry_index);
  assign we      = cmd.clear_step || (cmd.wr_entry && wr_ok);
  assign waddr   = cmd.clear_step ? clr_addr : wr_slot[IW-1:0];
  assign wdata   = cmd.clear_step ? entry_t'('0) : entry_t'({dest_start, src_start, span_len});

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[addr[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign status.clear_done = (clr_addr == IW'(DEPTH - 1));

  // range compare on the entry read last cycle, end of range without wrap
  assign diff      = cur_val - rdata.src;
  assign hit       = (cur_val >= rdata.src) && (diff < rdata.len);
  assign term      = (rdata == entry_t'('0));
  assign stage_end = rd_vld && (term || hit || rd_last);
  assign rd_en     = cmd.scan && !stage_end && (ent < EW'(ENTRIES_PER_STAGE));

  assign status.scan_done = stage_end && (stg == SW'(NUM_STAGES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else if (cmd.start_scan || stage_end) begin
      rd_vld <= 1'b0;
    end else if (cmd.scan) begin
      rd_vld <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_scan) begin
      cur_val <= value;
      stg     <= '0;
      ent     <= '0;
      addr    <= '0;
      base    <= '0;
    end else if (cmd.scan) begin
      if (stage_end) begin
        if (hit && !term) begin
          cur_val <= rdata.dest + diff;
        end
        stg  <= stg + 1'b1;
        ent  <= '0;
        base <= base + AW'(ENTRIES_PER_STAGE);
        addr <= base + AW'(ENTRIES_PER_STAGE);
      end else if (rd_en) begin
        rd_last <= (ent == EW'(ENTRIES_PER_STAGE - 1));
        ent     <= ent + 1'b1;
        addr    <= addr + 1'b1;
      end
    end
  end

  assign lowest_next = (cur_val < lowest) ? cur_val : lowest;

  always_ff @(posedge clk) begin
    if (rst) begin
      lowest <= '1;
    end else if (cmd.clr_low) begin
      lowest <= '1;
    end else if (cmd.finish) begin
      lowest <= lowest_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      mapped_value  <= cur_val;
      lowest_so_far <= lowest_next;
    end
  end

`ifndef SYNTH
  a_low_not_above: assert property (@(posedge clk) disable iff (rst)
    done |-> lowest_so_far <= mapped_value)
    else $error("lowest result above mapped value");

  a_scan_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.start_scan |=> !rd_vld && stg == '0 && ent == '0)
    else $error("scan pointers not restarted");
`endif

endmodule

// ----- hw/rtl/multi_stage_range_remap.sv -----
// ----------------------------------------------------------------------------
// multi_stage_range_remap
// Multi-stage range table translation with a lowest-result tracker.
// ----------------------------------------------------------------------------
// scan: a taken translate word walks the stages in order, reading entries
//   through the single table read port until a hit, a zero entry or the last
//   entry of a stage; after the last stage, finish gives the result strobe
// throughput: one translate word at a time; write and clear words leave busy
//   low
// reset: a clearing pass zeroes the whole table with busy high; the receiver
//   cannot stall
// ----------------------------------------------------------------------------
module multi_stage_range_remap
  import msrr_pkg::*;
#(
  parameter int unsigned NUM_STAGES        = 7,
  parameter int unsigned ENTRIES_PER_STAGE = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [2:0]  stage,
  input  logic [5:0]  entry_index,
  input  logic [31:0] dest_start,
  input  logic [31:0] src_start,
  input  logic [31:0] span_len,
  input  logic [31:0] value,
  output logic        done,
  output logic [31:0] mapped_value,
  output logic [31:0] lowest_so_far
);

  cmd_t    cmd;
  status_t status;

  msrr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .mode   (mode),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  msrr_datapath #(
    .NUM_STAGES        (NUM_STAGES),
    .ENTRIES_PER_STAGE (ENTRIES_PER_STAGE)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stage         (stage),
    .entry_index   (entry_index),
    .dest_start    (dest_start),
    .src_start     (src_start),
    .span_len      (span_len),
    .value         (value),
    .status        (status),
    .done          (done),
    .mapped_value  (mapped_value),
    .lowest_so_far (lowest_so_far)
  );

endmodule
